// ----- rtl/snat_pkg.sv -----
`timescale 1ns / 1ps
package snat_pkg;

  localparam int unsigned CONN_SETS = 256;
  localparam int unsigned CONN_WAYS = 4;
  localparam int unsigned RULE_SETS = 64;
  localparam int unsigned RULE_WAYS = 4;

  // set counts are powers of two, the set index is the low bits of the fold
  localparam int unsigned CONN_IDX_W = (CONN_SETS > 1) ? $clog2(CONN_SETS) : 1;
  localparam int unsigned RULE_IDX_W = (RULE_SETS > 1) ? $clog2(RULE_SETS) : 1;
  localparam int unsigned CONN_WAY_W = (CONN_WAYS > 1) ? $clog2(CONN_WAYS) : 1;
  localparam int unsigned RULE_WAY_W = (RULE_WAYS > 1) ? $clog2(RULE_WAYS) : 1;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  typedef enum logic [1:0] {
    MODE_EGRESS  = 2'd0,
    MODE_INGRESS = 2'd1,
    MODE_RULE    = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_PASS      = 3'd0,
    ACT_EST       = 3'd1,
    ACT_NEW       = 3'd2,
    ACT_REPLY     = 3'd3,
    ACT_RULE_OK   = 3'd4,
    ACT_RULE_FULL = 3'd5
  } action_e;

  typedef struct packed {
    logic                  valid;
    logic                  reply;
    logic [CONN_WAY_W-1:0] recency;
    logic [63:0]           key_addrs;
    logic [39:0]           key_ports_proto;
    logic [31:0]           xlat_addr;
    logic [15:0]           xlat_port;
  } conn_way_t;

  typedef conn_way_t [CONN_WAYS-1:0] conn_row_t;

  typedef struct packed {
    logic        valid;
    logic [55:0] key;
    logic [47:0] xlat;
  } rule_way_t;

  typedef rule_way_t [RULE_WAYS-1:0] rule_row_t;

endpackage

// ----- rtl/snat_conntrack_engine_core.sv -----
`timescale 1ns / 1ps
// snat_conntrack_engine_core: ipv4 source nat with a connection table
//
// requests enter on the s_axis channel; s_axis_tuser carries the mode
// (egress packet, ingress packet, rule write), s_axis_tdata the header
// fields and the rule translation. one result leaves per request on the
// m_axis channel: translated header in m_axis_tdata, action in m_axis_tuser.
// a lookup or rule write is registered, read from the set memories in S_READ,
// matched in S_LOOK and loaded into the output register; a new translation
// also writes its forward entry in S_LOOK while it reads a second connection
// set, then writes the reply entry and loads the result in S_INS2. the
// connection table and the rule table are synchronous memories with one read
// port and one write port each, one row per set holding all ways.
// reset clears the per-set init flags, so every connection set reads as empty
// with recency equal to the way index and every rule set reads as empty; no clearing pass is needed.
// a result waits in the output register while m_axis_tready is low, and no
// new request is taken until it has been delivered.
module snat_conntrack_engine_core
  import snat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // ether_type[15:0], ip_proto[23:16], src_addr[55:24], dst_addr[87:56],
  // src_port_in[103:88], dst_port_in[119:104], rule_nat_addr[151:120],
  // rule_nat_port[167:152]
  input  logic [167:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_src_addr[31:0], out_dst_addr[63:32], out_src_port[79:64],
  // out_dst_port[95:80]
  output logic [95:0]  m_axis_tdata,
  // action[2:0]
  output logic [2:0]   m_axis_tuser
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_INS2 = 2'd3;

  // ---------------------------------------------------------------- helpers
  function automatic conn_row_t conn_touch(conn_row_t row, logic [CONN_WAY_W-1:0] way);
    conn_row_t r;
    r = row;
    for (int w = 0; w < CONN_WAYS; w++) begin
      if (row[w].recency < row[way].recency) r[w].recency = row[w].recency + 1'b1;
    end
    r[way].recency = '0;
    return r;
  endfunction

  function automatic conn_row_t conn_insert(conn_row_t row, logic [63:0] ka, logic [39:0] kp,
                                            logic [31:0] xa, logic [15:0] xp, logic rep);
    conn_row_t             r;
    logic                  found;
    logic [CONN_WAY_W-1:0] way;
    logic [CONN_WAY_W-1:0] best;
    r     = row;
    found = 1'b0;
    way   = '0;
    best  = '0;
    for (int w = 0; w < CONN_WAYS; w++) begin
      if (!found && row[w].valid && row[w].key_addrs == ka && row[w].key_ports_proto == kp) begin
        found = 1'b1;
        way   = CONN_WAY_W'(w);
      end
    end
    for (int w = 0; w < CONN_WAYS; w++) begin
      if (!found && !row[w].valid) begin
        found = 1'b1;
        way   = CONN_WAY_W'(w);
      end
    end
    if (!found) begin
      for (int w = 0; w < CONN_WAYS; w++) begin
        if (row[w].recency >= best) begin
          best = row[w].recency;
          way  = CONN_WAY_W'(w);
        end
      end
    end
    r[way].valid           = 1'b1;
    r[way].reply           = rep;
    r[way].key_addrs       = ka;
    r[way].key_ports_proto = kp;
    r[way].xlat_addr       = xa;
    r[way].xlat_port       = xp;
    return conn_touch(r, way);
  endfunction

  function automatic logic [CONN_IDX_W-1:0] conn_hash(logic [31:0] sa, logic [31:0] da,
                                                      logic [15:0] sp, logic [15:0] dp,
                                                      logic [7:0] pr);
    logic [31:0] x;
    logic [15:0] f;
    x = sa ^ da ^ {sp, dp} ^ {24'd0, pr};
    f = x[15:0] ^ x[31:16];
    return f[CONN_IDX_W-1:0];
  endfunction

  // ---------------------------------------------------------------- request
  logic [1:0]  mode_q;
  logic [15:0] et_q;
  logic [7:0]  pr_q;
  logic [31:0] sa_q, da_q, na_q;
  logic [15:0] sp_q, dp_q, np_q;
  logic [1:0]  state_q, state_d;

  logic s_take;
  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      mode_q <= s_axis_tuser;
      et_q   <= s_axis_tdata[15:0];
      pr_q   <= s_axis_tdata[23:16];
      sa_q   <= s_axis_tdata[55:24];
      da_q   <= s_axis_tdata[87:56];
      sp_q   <= s_axis_tdata[103:88];
      dp_q   <= s_axis_tdata[119:104];
      na_q   <= s_axis_tdata[151:120];
      np_q   <= s_axis_tdata[167:152];
    end
  end

  // set indexes of the registered request
  logic [CONN_IDX_W-1:0] fidx, ridx;
  logic [RULE_IDX_W-1:0] rule_idx;
  logic [31:0]           rule_x;
  logic [15:0]           rule_f;
  logic [63:0]           ka;
  logic [39:0]           kp;
  logic [55:0]           rkey;

  assign fidx     = conn_hash(sa_q, da_q, sp_q, dp_q, pr_q);
  assign rule_x   = sa_q ^ {16'd0, sp_q} ^ {8'd0, pr_q, 16'd0};
  assign rule_f   = rule_x[15:0] ^ rule_x[31:16];
  assign rule_idx = rule_f[RULE_IDX_W-1:0];
  assign ka       = {sa_q, da_q};
  assign kp       = {sp_q, dp_q, pr_q};
  assign rkey     = {sa_q, sp_q, pr_q};

  // ---------------------------------------------------------------- memories
  conn_row_t conn_mem [CONN_SETS];
  rule_row_t rule_mem [RULE_SETS];
  conn_row_t conn_rd_q;
  rule_row_t rule_rd_q;
  logic [CONN_SETS-1:0] conn_init_q;
  logic [RULE_SETS-1:0] rule_init_q;

  logic                  conn_re, conn_we, rule_we;
  logic [CONN_IDX_W-1:0] conn_ra, conn_wa;
  conn_row_t             conn_wd;
  rule_row_t             rule_wd;

  always_ff @(posedge clk_i) begin
    if (conn_re) conn_rd_q <= conn_mem[conn_ra];
    if (conn_we) conn_mem[conn_wa] <= conn_wd;
    if (state_q == S_READ) rule_rd_q <= rule_mem[rule_idx];
    if (rule_we) rule_mem[rule_idx] <= rule_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_init_q <= '0;
      rule_init_q <= '0;
    end else begin
      if (conn_we) conn_init_q[conn_wa] <= 1'b1;
      if (rule_we) rule_init_q[rule_idx] <= 1'b1;
    end
  end

  // a set never written reads as empty with recency equal to the way index
  conn_row_t conn_rst_row, conn_fwd_row, ins2_row, fwd_row_q;
  rule_row_t rule_row;
  always_comb begin
    conn_rst_row = conn_rd_q;
    for (int w = 0; w < CONN_WAYS; w++) begin
      conn_rst_row[w].valid   = 1'b0;
      conn_rst_row[w].reply   = 1'b0;
      conn_rst_row[w].recency = CONN_WAY_W'(w);
    end
    conn_fwd_row = conn_init_q[fidx] ? conn_rd_q : conn_rst_row;
    rule_row     = rule_init_q[rule_idx] ? rule_rd_q : '0;
    // reply set equal to forward set: use the row just written
    if (ridx == fidx) ins2_row = fwd_row_q;
    else ins2_row = conn_init_q[ridx] ? conn_rd_q : conn_rst_row;
  end

  // ---------------------------------------------------------------- lookup
  logic                  hit, rule_hit, rule_slot_ok, pkt_ok;
  logic [CONN_WAY_W-1:0] hit_way;
  logic [RULE_WAY_W-1:0] rule_way, slot_way;
  logic [31:0]           rxa;
  logic [15:0]           rxp;

  always_comb begin
    hit          = 1'b0;
    hit_way      = '0;
    rule_hit     = 1'b0;
    rule_way     = '0;
    rule_slot_ok = 1'b0;
    slot_way     = '0;
    for (int w = 0; w < CONN_WAYS; w++) begin
      if (!hit && conn_fwd_row[w].valid && conn_fwd_row[w].key_addrs == ka &&
          conn_fwd_row[w].key_ports_proto == kp) begin
        hit     = 1'b1;
        hit_way = CONN_WAY_W'(w);
      end
    end
    for (int w = 0; w < RULE_WAYS; w++) begin
      if (!rule_hit && rule_row[w].valid && rule_row[w].key == rkey) begin
        rule_hit = 1'b1;
        rule_way = RULE_WAY_W'(w);
      end
    end
    for (int w = 0; w < RULE_WAYS; w++) begin
      if (!rule_slot_ok && !rule_row[w].valid) begin
        rule_slot_ok = 1'b1;
        slot_way     = RULE_WAY_W'(w);
      end
    end
    if (rule_hit) begin
      rule_slot_ok = 1'b1;
      slot_way     = rule_way;
    end
  end

  assign rxa    = rule_row[rule_way].xlat[47:16];
  assign rxp    = rule_row[rule_way].xlat[15:0];
  assign pkt_ok = (mode_q == MODE_EGRESS || mode_q == MODE_INGRESS) && et_q == ETHER_IPV4 &&
                  (pr_q == PROTO_TCP || pr_q == PROTO_UDP);

  // reply set of the new translation, read during the lookup cycle
  logic [CONN_IDX_W-1:0] rep_look_idx;
  assign rep_look_idx = conn_hash(da_q, rxa, dp_q, rxp, pr_q);

  // translation kept for the reply insert
  logic [31:0] xa_q;
  logic [15:0] xp_q;
  assign ridx = conn_hash(da_q, xa_q, dp_q, xp_q, pr_q);

  // ---------------------------------------------------------------- control
  logic        out_load;
  logic [95:0] out_data;
  logic [2:0]  out_act;

  always_comb begin
    state_d  = state_q;
    conn_re  = 1'b0;
    conn_ra  = fidx;
    conn_we  = 1'b0;
    conn_wa  = fidx;
    conn_wd  = conn_fwd_row;
    rule_we  = 1'b0;
    rule_wd  = rule_row;
    out_load = 1'b0;
    out_data = {dp_q, sp_q, da_q, sa_q};
    out_act  = ACT_PASS;
    unique case (state_q)
      S_IDLE: begin
        if (s_take) state_d = S_READ;
      end
      S_READ: begin
        conn_re = 1'b1;
        state_d = S_LOOK;
      end
      S_LOOK: begin
        state_d  = S_IDLE;
        out_load = 1'b1;
        if (mode_q == MODE_RULE) begin
          out_data = '0;
          if (rule_slot_ok) begin
            rule_we                 = 1'b1;
            rule_wd[slot_way].valid = 1'b1;
            rule_wd[slot_way].key   = rkey;
            rule_wd[slot_way].xlat  = {na_q, np_q};
            out_act                 = ACT_RULE_OK;
          end else begin
            out_act = ACT_RULE_FULL;
          end
        end else if (pkt_ok && hit) begin
          conn_we = 1'b1;
          conn_wd = conn_touch(conn_fwd_row, hit_way);
          if (mode_q == MODE_EGRESS) begin
            out_data = {dp_q, conn_fwd_row[hit_way].xlat_port, da_q,
                        conn_fwd_row[hit_way].xlat_addr};
            out_act  = ACT_EST;
          end else if (conn_fwd_row[hit_way].reply) begin
            out_data = {conn_fwd_row[hit_way].xlat_port, sp_q,
                        conn_fwd_row[hit_way].xlat_addr, sa_q};
            out_act  = ACT_REPLY;
          end
        end else if (pkt_ok && mode_q == MODE_EGRESS && rule_hit) begin
          // forward entry now, reply set read alongside for the next cycle
          conn_we  = 1'b1;
          conn_wd  = conn_insert(conn_fwd_row, ka, kp, rxa, rxp, 1'b0);
          conn_re  = 1'b1;
          conn_ra  = rep_look_idx;
          out_load = 1'b0;
          state_d  = S_INS2;
        end
      end
      S_INS2: begin
        conn_we  = 1'b1;
        conn_wa  = ridx;
        conn_wd  = conn_insert(ins2_row, {da_q, xa_q}, {dp_q, xp_q, pr_q}, sa_q, sp_q, 1'b1);
        out_load = 1'b1;
        out_data = {dp_q, xp_q, da_q, xa_q};
        out_act  = ACT_NEW;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOOK) begin
      xa_q      <= rxa;
      xp_q      <= rxp;
      fwd_row_q <= conn_wd;
    end
  end

  // ---------------------------------------------------------------- output
  logic        m_valid_q;
  logic [95:0] m_data_q;
  logic [2:0]  m_act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= out_data;
      m_act_q  <= out_act;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_act_q;

endmodule

// ----- rtl/snat_checker.sv -----
`timescale 1ns / 1ps
module snat_checker
  import snat_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // one request in flight: no accept while a result is held
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken too early");

  // rule write results carry no header
  a_rule_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ACT_RULE_OK || m_axis_tuser == ACT_RULE_FULL))
      |-> m_axis_tdata == '0)
    else $error("rule result with nonzero header");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind snat_conntrack_engine_core snat_checker u_snat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
